/* rtl/core/ole_pkg.sv */
package ole_pkg;

  // list geometry
  localparam int DEPTH    = 16;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // access to the entry store: write port and read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // ring slot that lies off places behind the head
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                               input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

/* rtl/core/ole_mem.sv */
module ole_mem
  import ole_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

/* rtl/core/ordered_list_engine.sv */
// Bounded list of up to DEPTH signed 32-bit values held as a ring in one
// single-port-read memory. An operation is taken when start is high and busy
// is low. Inserts finish while the block stays idle and may follow each
// other directly. Search and delete walk the list from the head one entry
// a cycle through the memory read port; a delete that matches then moves
// each later entry up one place. Each operation yields one result, shown
// for exactly one cycle with out_valid high, in the cycle after the
// operation completes; the receiver cannot stall, so it must take every
// result in the cycle it appears. out_count always shows the current number
// of entries.
module ordered_list_engine
  import ole_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [KIND_W-1:0]          in_kind,
  input  logic signed [DATA_W-1:0]   in_value,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POS_W-1:0]           out_position,
  output logic [POS_W-1:0]           out_count
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                del_r, del_nxt;
  logic [DATA_W-1:0]   val_r, val_nxt;
  logic                valid_r, valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;

  mem_req_t            req;
  logic [DATA_W-1:0]   rd_data;
  logic [CNT_W-1:0]    idx_p1;
  logic [CNT_W-1:0]    idx_p2;
  logic                full;

  assign idx_p1 = idx_r + CNT_W'(1);
  assign idx_p2 = idx_r + CNT_W'(2);
  assign full   = (count_r == CNT_W'(DEPTH));

  ole_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // operation sequencer
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    del_nxt    = del_r;
    val_nxt    = val_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    pos_nxt    = pos_r;
    req        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_OK;
          pos_nxt    = '0;
          if (in_kind == KIND_INS_FRONT || in_kind == KIND_INS_END) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              req.we    = 1'b1;
              req.wdata = $unsigned(in_value);
              count_nxt = count_r + CNT_W'(1);
              if (in_kind == KIND_INS_FRONT) begin
                head_nxt  = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - ADDR_W'(1);
                req.waddr = head_nxt;
              end else begin
                req.waddr = slot_of(head_r, count_r);
              end
            end
          end else if (count_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            // start the walk at the head
            valid_nxt = 1'b0;
            req.re    = 1'b1;
            req.raddr = head_r;
            idx_nxt   = '0;
            del_nxt   = (in_kind == KIND_DELETE);
            val_nxt   = $unsigned(in_value);
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // rd_data holds the entry at offset idx_r
        if (rd_data == val_r) begin
          if (!del_r) begin
            valid_nxt  = 1'b1;
            status_nxt = ST_OK;
            pos_nxt    = POS_W'(idx_p1);
            state_nxt  = S_IDLE;
          end else if (idx_p1 == count_r) begin
            valid_nxt  = 1'b1;
            status_nxt = ST_OK;
            pos_nxt    = '0;
            count_nxt  = count_r - CNT_W'(1);
            state_nxt  = S_IDLE;
          end else begin
            // start reading the entry behind the match
            req.re    = 1'b1;
            req.raddr = slot_of(head_r, idx_p1);
            state_nxt = S_SHIFT;
          end
        end else if (idx_p1 == count_r) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_NOT_FOUND;
          pos_nxt    = '0;
          state_nxt  = S_IDLE;
        end else begin
          req.re    = 1'b1;
          req.raddr = slot_of(head_r, idx_p1);
          idx_nxt   = idx_p1;
        end
      end
      S_SHIFT: begin
        // move the entry at idx_r + 1 into idx_r, fetch the next one
        req.we    = 1'b1;
        req.waddr = slot_of(head_r, idx_r);
        req.wdata = rd_data;
        idx_nxt   = idx_p1;
        if (idx_p2 == count_r) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_OK;
          pos_nxt    = '0;
          count_nxt  = count_r - CNT_W'(1);
          state_nxt  = S_IDLE;
        end else begin
          req.re    = 1'b1;
          req.raddr = slot_of(head_r, idx_p2);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    del_r    <= del_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = valid_r;
  assign out_status   = status_r;
  assign out_position = pos_r;
  assign out_count    = POS_W'(count_r);

endmodule

/* test/ordered_list_engine_test.sv */
module ordered_list_engine_test;
  import ole_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int RANDOM_OPS   = 450;
  localparam int PLAN_ROWS    = 22;

  // one result as the block reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [POS_W-1:0]    count;
  } list_result_t;

  // directed row: operation, first value, repeat count, typed-in result if any
  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    int                       reps;
    bit                       typed;
    list_result_t             want;
  } list_op_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [KIND_W-1:0]        in_kind;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [POS_W-1:0]         out_position;
  logic [POS_W-1:0]         out_count;

  // shadow copy of the ring
  logic signed [DATA_W-1:0] ring [DEPTH];
  int                       ring_head = 0;
  int                       ring_count = 0;

  list_result_t             awaited_results [$];
  list_result_t             oldest_result;
  list_op_row_t             plan [PLAN_ROWS];
  int                       mismatches = 0;
  int                       idle_cycles = 0;

  ordered_list_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // apply one operation to the shadow ring and return what the block should report
  function automatic list_result_t list_apply(input logic [KIND_W-1:0] kind,
                                              input logic signed [DATA_W-1:0] value);
    list_result_t r;
    int           hit;
    int           i;
    r.status   = ST_OK;
    r.position = '0;
    if (kind == KIND_INS_FRONT || kind == KIND_INS_END) begin
      if (ring_count >= DEPTH) begin
        r.status = ST_FULL;
      end else if (kind == KIND_INS_FRONT) begin
        ring_head = (ring_head + DEPTH - 1) % DEPTH;
        ring[ring_head] = value;
        ring_count++;
      end else begin
        ring[(ring_head + ring_count) % DEPTH] = value;
        ring_count++;
      end
    end else if (ring_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // first match counting from the head
      hit = ring_count;
      for (i = 0; i < ring_count; i++) begin
        if (hit == ring_count && ring[(ring_head + i) % DEPTH] == value) begin
          hit = i;
        end
      end
      if (hit == ring_count) begin
        r.status = ST_NOT_FOUND;
      end else if (kind == KIND_SEARCH) begin
        r.position = POS_W'(hit + 1);
      end else begin
        // close the gap behind the deleted entry
        for (i = hit; i + 1 < ring_count; i++) begin
          ring[(ring_head + i) % DEPTH] = ring[(ring_head + i + 1) % DEPTH];
        end
        ring_count--;
      end
    end
    r.count = POS_W'(ring_count);
    return r;
  endfunction

  // small values two times in five and extremes one in ten, so that duplicates and matches are common
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = int'($urandom_range(0, 9));
    if (r < 4) begin
      return DATA_W'(int'($urandom_range(0, 7)) - 4);
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // idle cycles after a transfer: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(8, 40));
  endfunction

  // present one operation and hold it until the block takes it
  task automatic send_op(input logic [KIND_W-1:0] kind,
                         input logic signed [DATA_W-1:0] value,
                         input bit typed, input list_result_t want, input int gap);
    list_result_t predicted;
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    predicted = list_apply(kind, value);
    awaited_results.push_back(typed ? want : predicted);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result checking against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: status=%0d position=%0d count=%0d",
                   out_status, out_position, out_count);
        end
        mismatches++;
      end else begin
        oldest_result = awaited_results.pop_front();
        if (out_status !== oldest_result.status || out_position !== oldest_result.position ||
            out_count !== oldest_result.count) begin
          if (mismatches < 10) begin
            $display("mismatch: expected status=%0d position=%0d count=%0d, got %0d %0d %0d",
                     oldest_result.status, oldest_result.position, oldest_result.count,
                     out_status, out_position, out_count);
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
    bit                       filling;
    int                       r;
    int                       gap;

    rst_n    = 1'b0;
    start    = 1'b0;
    in_kind  = KIND_INS_FRONT;
    in_value = '0;

    plan = '{
      // empty list
      '{KIND_SEARCH,    32'h0000_0000, 1, 1'b1, '{ST_EMPTY, 5'd0, 5'd0}},
      '{KIND_DELETE,    32'h8000_0000, 1, 1'b1, '{ST_EMPTY, 5'd0, 5'd0}},
      // extremes at both ends, head wraps round the ring
      '{KIND_INS_FRONT, 32'h7fff_ffff, 1, 1'b1, '{ST_OK, 5'd0, 5'd1}},
      '{KIND_INS_END,   32'h8000_0000, 1, 1'b1, '{ST_OK, 5'd0, 5'd2}},
      '{KIND_INS_FRONT, 32'hffff_ffff, 1, 1'b1, '{ST_OK, 5'd0, 5'd3}},
      '{KIND_INS_END,   32'h0000_0000, 1, 1'b1, '{ST_OK, 5'd0, 5'd4}},
      '{KIND_SEARCH,    32'h8000_0000, 1, 1'b0, '0},
      // no match
      '{KIND_SEARCH,    32'h0000_1234, 1, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd4}},
      '{KIND_DELETE,    32'h0000_1234, 1, 1'b1, '{ST_NOT_FOUND, 5'd0, 5'd4}},
      // duplicates: only the first from the head counts
      '{KIND_INS_END,   32'h7fff_ffff, 1, 1'b0, '0},
      '{KIND_SEARCH,    32'h7fff_ffff, 1, 1'b0, '0},
      '{KIND_DELETE,    32'h7fff_ffff, 1, 1'b0, '0},
      '{KIND_SEARCH,    32'h7fff_ffff, 1, 1'b0, '0},
      '{KIND_DELETE,    32'hffff_ffff, 1, 1'b0, '0},
      // fill up, then inserts into a full list
      '{KIND_INS_END,   32'h5a5a_0000, 13, 1'b0, '0},
      '{KIND_INS_FRONT, 32'h0000_0001, 1, 1'b1, '{ST_FULL, 5'd0, 5'd16}},
      '{KIND_INS_END,   32'h0000_0002, 1, 1'b1, '{ST_FULL, 5'd0, 5'd16}},
      // match at the last place, tail and middle deletes
      '{KIND_SEARCH,    32'h5a5a_000c, 1, 1'b0, '0},
      '{KIND_DELETE,    32'h5a5a_000c, 1, 1'b0, '0},
      '{KIND_DELETE,    32'h7fff_ffff, 1, 1'b0, '0},
      '{KIND_SEARCH,    32'h0000_0000, 1, 1'b0, '0},
      '{KIND_INS_FRONT, 32'h0000_0001, 1, 1'b0, '0}
    };

    // reset
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (plan[p]) begin
      for (int k = 0; k < plan[p].reps; k++) begin
        send_op(plan[p].kind, plan[p].value + k, plan[p].typed, plan[p].want, pick_gap());
      end
    end

    // random part: alternate filling and draining phases
    for (int n = 0; n < RANDOM_OPS; n++) begin
      filling = ((n / 40) % 2) == 0;
      r = int'($urandom_range(0, 99));
      if (r < (filling ? 70 : 25)) begin
        kind  = $urandom_range(0, 1) ? KIND_INS_END : KIND_INS_FRONT;
        value = pick_value();
      end else begin
        kind = $urandom_range(0, 1) ? KIND_DELETE : KIND_SEARCH;
        if (ring_count > 0 && $urandom_range(0, 9) < 7) begin
          value = ring[(ring_head + int'($urandom_range(0, ring_count - 1))) % DEPTH];
        end else begin
          value = pick_value();
        end
      end
      // stretches without idling
      gap = ((n / 50) % 4 == 3) ? 0 : pick_gap();
      send_op(kind, value, 1'b0, '0, gap);
    end
    start <= 1'b0;

    // drain
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
